FILE: rtl/csa_pkg.sv
// Shared types, constants and field tables for the clock set and alarm controller.
// No dependencies; imported by every module of the block.
package csa_pkg;

    localparam int HOLD_W           = 16;
    localparam int PRESS_PERIOD_DEF = 20;
    localparam int NUM_FIELDS       = 7;
    localparam int FIELD_W          = 7;
    localparam int TIME_W           = 36;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_MODIFY   = 2'd1,
        MODE_SCHEDULE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_REPEAT     = 2'd1,
        CFG_BLINK      = 2'd2
    } t_cfg_idx;

    localparam logic [2:0] F_SEC  = 3'd0;
    localparam logic [2:0] F_YEAR = 3'd6;

    localparam logic [7:0] LONG_PRESS_RST = 8'd40;
    localparam logic [3:0] REPEAT_RST     = 4'd4;
    localparam logic [3:0] BLINK_RST      = 4'd10;

    typedef logic [FIELD_W-1:0] t_field_val;

    // Field tables, index 0 year .. 6 seconds
    localparam logic [7:0] WRAP_LIMIT [NUM_FIELDS] =
        '{8'd100, 8'd13, 8'd32, 8'd8, 8'd24, 8'd60, 8'd60};
    localparam t_field_val WRAP_TO [NUM_FIELDS] =
        '{7'd1, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0};
    localparam t_field_val FIELD_MASK [NUM_FIELDS] =
        '{7'h7F, 7'h0F, 7'h1F, 7'h07, 7'h1F, 7'h3F, 7'h3F};
    localparam t_field_val EDIT_RESET [NUM_FIELDS] =
        '{7'd23, 7'd8, 7'd23, 7'd5, 7'd5, 7'd15, 7'd43};

    // One registered tick: decoded presses, raw inc hold count, live time
    typedef struct packed {
        logic                mode_press;
        logic                inc_press;
        logic                next_press;
        logic [HOLD_W-1:0]   inc_hold;
        logic [6:0]          year;
        logic [3:0]          month;
        logic [4:0]          date;
        logic [2:0]          weekday;
        logic [4:0]          hour;
        logic [5:0]          minute;
        logic [5:0]          second;
    } t_tick;

    typedef struct packed {
        t_mode               mode;
        logic [2:0]          sel;
        logic [TIME_W-1:0]   edit_time;
        logic                blink_on;
        logic                rtc_write;
        logic                alarm_armed;
        logic                alarm_hit;
    } t_result;

    // Step one field by one with its wrap rule
    function automatic t_field_val csa_step_val(input t_field_val v, input logic [2:0] idx);
        logic [7:0] inc;
        t_field_val res;
        inc = {1'b0, v} + 8'd1;
        if (inc >= WRAP_LIMIT[idx]) begin
            res = WRAP_TO[idx];
        end else begin
            res = inc[FIELD_W-1:0];
        end
        return res & FIELD_MASK[idx];
    endfunction

endpackage

FILE: rtl/csa_press.sv
// Button press decode: a hold count equal to 1 modulo the press period is a press.
// Depends on csa_pkg. Divisibility test of (hold - 1) by a reciprocal multiply.
module csa_press import csa_pkg::*; #(
    parameter int PRESS_PERIOD = PRESS_PERIOD_DEF
) (
    input  logic [HOLD_W-1:0] i_hold,
    output logic              o_press
);

    localparam int FracW = HOLD_W + $clog2(PRESS_PERIOD);
    localparam int ProdW = HOLD_W + FracW;
    localparam logic [FracW-1:0] Recip =
        FracW'(((2 ** FracW) + PRESS_PERIOD - 1) / PRESS_PERIOD);

    logic [HOLD_W-1:0] hold_m1;
    logic [ProdW-1:0]  prod;

    assign hold_m1 = i_hold - HOLD_W'(1);
    // x is a multiple of the period exactly when the low bits of x * ceil(2^F/P) are below the reciprocal
    assign prod    = {{FracW{1'b0}}, hold_m1} * {{HOLD_W{1'b0}}, Recip};
    assign o_press = (i_hold != '0) && (prod[FracW-1:0] < Recip);

endmodule

FILE: rtl/csa_core.sv
// Controller state and per-tick update: mode, field select, edit values, alarm, blink.
// Depends on csa_pkg. State advances on i_step; o_res is the result of that tick.
module csa_core import csa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  t_tick                 i_tick,
    output t_result               o_res
);

    logic [7:0] r_long_press;
    logic [3:0] r_repeat;
    logic [3:0] r_blink;

    t_mode      r_mode,  n_mode;
    logic [2:0] r_sel,   n_sel;
    logic [2:0] r_next,  n_next;
    t_field_val r_ev    [NUM_FIELDS];
    t_field_val n_ev    [NUM_FIELDS];
    t_field_val r_alarm [NUM_FIELDS];
    t_field_val n_alarm [NUM_FIELDS];
    logic       r_armed, n_armed;
    logic       r_reload, n_reload;
    logic [3:0] r_hold_cnt, n_hold_cnt;
    logic [3:0] r_blink_cnt, n_blink_cnt;
    logic       r_blink_phase, n_blink_phase;

    t_field_val live [NUM_FIELDS];
    logic       wr;
    logic       hit;
    logic       match;

    assign live[0] = i_tick.year;
    assign live[1] = {3'b0, i_tick.month};
    assign live[2] = {2'b0, i_tick.date};
    assign live[3] = {4'b0, i_tick.weekday};
    assign live[4] = {2'b0, i_tick.hour};
    assign live[5] = {1'b0, i_tick.minute};
    assign live[6] = {1'b0, i_tick.second};

    always_comb begin
        n_mode        = r_mode;
        n_sel         = r_sel;
        n_next        = r_next;
        n_ev          = r_ev;
        n_alarm       = r_alarm;
        n_armed       = r_armed;
        n_reload      = r_reload;
        n_hold_cnt    = r_hold_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_blink_phase = r_blink_phase;
        wr            = 1'b0;
        hit           = 1'b0;
        match         = 1'b1;

        if (i_tick.mode_press) begin
            unique case (r_mode)
                MODE_NORMAL:   n_mode = MODE_MODIFY;
                MODE_MODIFY:   n_mode = MODE_SCHEDULE;
                MODE_SCHEDULE: n_mode = MODE_NORMAL;
                default:       n_mode = MODE_NORMAL;
            endcase
            n_reload = 1'b1;
        end

        if (n_mode != MODE_NORMAL) begin
            if (n_reload) begin
                n_sel    = F_SEC;
                n_next   = F_SEC;
                n_ev     = live;
                n_reload = 1'b0;
            end
            if (i_tick.inc_press) begin
                n_hold_cnt = '0;
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    if (F_YEAR - n_sel == 3'(k)) begin
                        n_ev[k] = csa_step_val(n_ev[k], 3'(k));
                    end
                end
                if (n_sel < F_YEAR) begin
                    n_next = n_sel + 3'd1;
                end
            end
            // long hold: auto-repeat on top of any press this tick
            if (i_tick.inc_hold >= {8'b0, r_long_press}) begin
                n_hold_cnt = n_hold_cnt + 4'd1;
                if (n_hold_cnt >= r_repeat) begin
                    n_hold_cnt = '0;
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (F_YEAR - n_sel == 3'(k)) begin
                            n_ev[k] = csa_step_val(n_ev[k], 3'(k));
                        end
                    end
                end
            end
            if (i_tick.next_press) begin
                if (n_mode != MODE_SCHEDULE) begin
                    wr = 1'b1;
                end
                if (n_next == n_sel && n_sel < F_YEAR) begin
                    n_next = n_sel + 3'd1;
                end
                if (n_sel == F_YEAR) begin
                    if (n_mode == MODE_SCHEDULE) begin
                        n_armed = 1'b1;
                        n_alarm = n_ev;
                    end
                    n_reload = 1'b1;
                    n_mode   = MODE_NORMAL;
                end
                n_sel = n_next;
            end
            n_blink_cnt = n_blink_cnt + 4'd1;
            if (n_blink_cnt >= r_blink) begin
                n_blink_cnt   = '0;
                n_blink_phase = !n_blink_phase;
            end
        end

        if (n_armed) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (n_alarm[k] != live[k]) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                n_armed = 1'b0;
                hit     = 1'b1;
            end
        end
    end

    always_comb begin
        o_res.mode        = n_mode;
        o_res.sel         = n_sel;
        o_res.edit_time   = {n_ev[0], n_ev[1][3:0], n_ev[2][4:0], n_ev[3][2:0],
                             n_ev[4][4:0], n_ev[5][5:0], n_ev[6][5:0]};
        o_res.blink_on    = n_blink_phase;
        o_res.rtc_write   = wr;
        o_res.alarm_armed = n_armed;
        o_res.alarm_hit   = hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= LONG_PRESS_RST;
            r_repeat      <= REPEAT_RST;
            r_blink       <= BLINK_RST;
            r_mode        <= MODE_NORMAL;
            r_sel         <= F_SEC;
            r_next        <= 3'd1;
            r_ev          <= EDIT_RESET;
            r_alarm       <= '{default: '0};
            r_armed       <= 1'b0;
            r_reload      <= 1'b0;
            r_hold_cnt    <= '0;
            r_blink_cnt   <= '0;
            r_blink_phase <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                    CFG_REPEAT:     r_repeat     <= i_cfg_data[3:0];
                    CFG_BLINK:      r_blink      <= i_cfg_data[3:0];
                    default:        ;
                endcase
            end
            if (i_step) begin
                r_mode        <= n_mode;
                r_sel         <= n_sel;
                r_next        <= n_next;
                r_ev          <= n_ev;
                r_alarm       <= n_alarm;
                r_armed       <= n_armed;
                r_reload      <= n_reload;
                r_hold_cnt    <= n_hold_cnt;
                r_blink_cnt   <= n_blink_cnt;
                r_blink_phase <= n_blink_phase;
            end
        end
    end

    ast_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_sel) && $stable(r_armed))
        else $error("controller state moved without a tick");

    ast_normal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_mode == MODE_NORMAL && !i_tick.mode_press
        |=> $stable(r_sel) && $stable(r_blink_phase) && $stable(r_hold_cnt))
        else $error("edit state changed in normal mode");

    ast_write_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.rtc_write |-> i_tick.next_press && o_res.mode != MODE_SCHEDULE)
        else $error("rtc write outside a modify next press");

    ast_hit_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.alarm_hit |-> !o_res.alarm_armed)
        else $error("alarm still armed after firing");

endmodule

FILE: rtl/clock_set_and_alarm_controller.sv
// Clock set and alarm controller: input tick register, controller core, result register.
// Usage notes:
//   Input channel (i_valid / o_stall) carries one scan tick: three button hold counts and
//   the live calendar time. Output channel (o_valid / i_stall) carries one result per
//   tick: mode, selected field, packed edit time, blink phase, RTC write strobe, alarm
//   armed flag and alarm hit pulse.
//   A transferred tick is decoded into press flags and registered in the tick register; its
//   result is registered in the result register when the tick steps, and offered from then on.
//   Throughput is one tick per cycle while the receiver does not stall; the state update is a
//   single combinational pass between the tick register and the result register.
//   When the receiver stalls, the result holds and the tick register keeps one more
//   tick; o_stall rises only when both are full and the output is stalled.
//   Configuration (long press, repeat, blink tick counts) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no tick is in flight.
//   Synchronous active-low reset empties both registers and loads the default edit time,
//   normal mode, seconds selected, alarm disarmed and the default configuration.
// Depends on csa_pkg, csa_press, csa_core.
module clock_set_and_alarm_controller import csa_pkg::*; #(
    parameter int PRESS_PERIOD = PRESS_PERIOD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [HOLD_W-1:0]     i_mode_hold,
    input  logic [HOLD_W-1:0]     i_inc_hold,
    input  logic [HOLD_W-1:0]     i_next_hold,
    input  logic [6:0]            i_rtc_year,
    input  logic [3:0]            i_rtc_month,
    input  logic [4:0]            i_rtc_date,
    input  logic [2:0]            i_rtc_weekday,
    input  logic [4:0]            i_rtc_hour,
    input  logic [5:0]            i_rtc_minute,
    input  logic [5:0]            i_rtc_second,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_mode,
    output logic [2:0]            o_selected_field,
    output logic [TIME_W-1:0]     o_edit_time,
    output logic                  o_blink_on,
    output logic                  o_rtc_write,
    output logic                  o_alarm_armed,
    output logic                  o_alarm_hit
);

    logic    mode_press;
    logic    inc_press;
    logic    next_press;
    logic    in_xfer;
    logic    step;
    logic    r_in_valid;
    t_tick   r_tick;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;

    csa_press #(.PRESS_PERIOD(PRESS_PERIOD)) u_mode_press (
        .i_hold  (i_mode_hold),
        .o_press (mode_press)
    );

    csa_press #(.PRESS_PERIOD(PRESS_PERIOD)) u_inc_press (
        .i_hold  (i_inc_hold),
        .o_press (inc_press)
    );

    csa_press #(.PRESS_PERIOD(PRESS_PERIOD)) u_next_press (
        .i_hold  (i_next_hold),
        .o_press (next_press)
    );

    // tick moves into the result register whenever that register is free or draining
    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;
    assign in_xfer = i_valid && !o_stall;

    csa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_tick     (r_tick),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tick.mode_press <= mode_press;
            r_tick.inc_press  <= inc_press;
            r_tick.next_press <= next_press;
            r_tick.inc_hold   <= i_inc_hold;
            r_tick.year       <= i_rtc_year;
            r_tick.month      <= i_rtc_month;
            r_tick.date       <= i_rtc_date;
            r_tick.weekday    <= i_rtc_weekday;
            r_tick.hour       <= i_rtc_hour;
            r_tick.minute     <= i_rtc_minute;
            r_tick.second     <= i_rtc_second;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode           = r_out.mode;
    assign o_selected_field = r_out.sel;
    assign o_edit_time      = r_out.edit_time;
    assign o_blink_on       = r_out.blink_on;
    assign o_rtc_write      = r_out.rtc_write;
    assign o_alarm_armed    = r_out.alarm_armed;
    assign o_alarm_hit      = r_out.alarm_hit;

endmodule
